// File: hdl/hash_set_linear_probe_insert_unit_defines.svh
// Assertion macros used by the hash set RTL.
`ifndef HASH_SET_LINEAR_PROBE_INSERT_UNIT_DEFINES_SVH
`define HASH_SET_LINEAR_PROBE_INSERT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/hslp_pkg.sv
`default_nettype none

package hslp_pkg;

   // The table depth must stay a power of two: the home slot is a bit-select
   // of the key and the probe pointer wraps by overflow.
   localparam int unsigned TABLE_SIZE = 1024;
   localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
   localparam int unsigned STEP_W     = $clog2(TABLE_SIZE + 1);
   localparam int unsigned KEY_W      = 31;
   localparam int unsigned STATUS_W   = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_PROBE
   } fsm_type;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

`default_nettype wire

// File: hdl/hash_set_linear_probe_insert_unit.sv
// The result beat is offered when the walk stops at an empty slot, at its own key or at the end of one lap,
// where probes counts the occupied slots stepped past; a full table reports TABLE_SIZE probes.
// One insert is in flight at a time: a new request waits until the result has entered the output register.
// The walk reads one slot per cycle through the one memory read port.
// Reset (synchronous, active high) starts a clearing pass that marks every slot empty; no request
// beat is accepted until it finishes.
`default_nettype none

`include "hash_set_linear_probe_insert_unit_defines.svh"

module hash_set_linear_probe_insert_unit
   import hslp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KEY_W-1:0]    req_key,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [STEP_W-1:0]        rsp_probes
);

   // Control state.
   fsm_type             state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;

   // Walk state for the key being inserted.
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // The table itself: one entry per slot, a used flag beside the key.
   // Each read is registered and issued with the next position, so rd_ff holds the entry for pos_ff in the same cycle.
   entry_type           mem [TABLE_SIZE];
   entry_type           rd_ff;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   entry_type           wr_data;

   // Output register. It lets a finished result wait while the walk stalls only
   // on its own last step.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STEP_W-1:0]   rsp_probes_ff, rsp_probes_in;

   logic                out_free;
   logic                slot_empty;
   logic                key_hit;
   logic                last_slot;
   logic                walk_done;
   logic                finish;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign slot_empty = !rd_ff.used;
   assign key_hit    = rd_ff.used && (rd_ff.key == key_ff);
   assign last_slot  = (step_ff == STEP_W'(TABLE_SIZE - 1));
   assign walk_done  = slot_empty || key_hit || last_slot;
   assign finish     = (state_ff == FSM_PROBE) && walk_done && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (clr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_PROBE;
            end
         end
         FSM_PROBE: begin
            if (finish) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_ready     = 1'b0;
      clr_in        = clr_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = '{used: 1'b1, key: key_ff};
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probes_in = rsp_probes_ff;
      case (state_ff)
         FSM_CLEAR: begin
            // Sweep the table once, one slot a cycle, marking every slot empty.
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{used: 1'b0, key: '0};
            clr_in  = SLOT_W'(clr_ff + 1'b1);
         end
         FSM_IDLE: begin
            // A new key starts at its home slot, key modulo the table size.
            req_ready = 1'b1;
            if (req_valid) begin
               key_in  = req_key;
               pos_in  = req_key[SLOT_W-1:0];
               step_in = '0;
               rd_en   = 1'b1;
               rd_addr = req_key[SLOT_W-1:0];
            end
         end
         FSM_PROBE: begin
            if (walk_done) begin
               // Hold here until the output register can take the result.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (slot_empty) begin
                     wr_en         = 1'b1;
                     rsp_status_in = ST_INSERTED;
                     rsp_slot_in   = pos_ff;
                     rsp_probes_in = step_ff;
                  end else if (key_hit) begin
                     rsp_status_in = ST_PRESENT;
                     rsp_slot_in   = pos_ff;
                     rsp_probes_in = step_ff;
                  end else begin
                     rsp_status_in = ST_FULL;
                     rsp_slot_in   = '0;
                     rsp_probes_in = STEP_W'(TABLE_SIZE);
                  end
               end
            end else begin
               // Occupied by another key: step to the next slot, wrapping at the end.
               pos_in  = SLOT_W'(pos_ff + 1'b1);
               step_in = STEP_W'(step_ff + 1'b1);
               rd_en   = 1'b1;
               rd_addr = SLOT_W'(pos_ff + 1'b1);
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Table memory. An insert writes at the edge that ends its walk, and the next
   // key is read only from the idle state that follows, so a read never races a write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_probes = rsp_probes_ff;

   // A full result always names slot zero and a complete walk.
   `ASSERT_IMPLY(a_full_result, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_FULL), (rsp_slot_ff == '0) && (rsp_probes_ff == STEP_W'(TABLE_SIZE)))
   // A stored or found key lies within one lap of its home slot.
   `ASSERT_IMPLY(a_hit_in_lap, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_FULL), rsp_probes_ff < STEP_W'(TABLE_SIZE))
   // An accepted key starts its walk at the home slot.
   `ASSERT_NEXT(a_walk_start, clock, reset, req_valid && req_ready, (state_ff == FSM_PROBE) && (step_ff == '0) && (pos_ff == key_ff[SLOT_W-1:0]))
   // The walk never runs past the last slot of one lap.
   `ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == FSM_PROBE, step_ff < STEP_W'(TABLE_SIZE))

endmodule

`default_nettype wire
